// ===== hdl/tlpq_pkg.sv =====
package tlpq_pkg;

  localparam int QUEUE_DEPTH = 128;
  localparam int NUM_LEVELS  = 3;

  localparam int DATA_W  = 32;
  localparam int CAP_W   = 8;
  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int LIM_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int ADDR_W  = $clog2(NUM_LEVELS * QUEUE_DEPTH);
  localparam int LVL_W   = 2;

  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [LIM_W-1:0] DEPTH_LIM = LIM_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_OVERFLOW = 3'd1,
    ST_INVALID  = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_t;

  localparam logic [LVL_W-1:0] LEVEL_NONE = 2'd0;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

endpackage

// ===== hdl/three_level_priority_queue.sv =====
// Three-level strict-priority FIFO queue.
//
// Request channel: pulse start with in_req_type, in_priority_level and
// in_element_value. A request transfers at a rising edge with start high
// and busy low. busy never rises, so one request may transfer every cycle.
// Insert (req 0) appends the value to the queue of its level (1..3);
// remove (req 1) pops the oldest entry of the lowest-numbered non-empty level.
//
// Result channel: every request gives one result in the cycle after its
// transfer, shown for one cycle with out_valid high. The receiver
// cannot stall, so nothing is held back. Throughput is one request per
// cycle; the removed value comes from the registered read of the shared
// entry memory (one port, one access per request).
//
// Configuration: cfg_queue_capacity sets the per-level capacity (values
// above the queue depth saturate). cfg_ready is always high; write only
// while no request is in flight.
//
// Reset (rst_n low, synchronous): all queues empty, capacity 128. The
// entry memory is not cleared; only written entries are ever read.
module three_level_priority_queue
  import tlpq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_req_type,
  input  logic [LVL_W-1:0]         in_priority_level,
  input  logic signed [DATA_W-1:0] in_element_value,
  output logic                     out_valid,
  output logic [2:0]               out_status,
  output logic signed [DATA_W-1:0] out_removed_value,
  output logic [LVL_W-1:0]         out_source_level,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CAP_W-1:0]         cfg_queue_capacity
);

  logic [CAP_W-1:0]  cap_r;
  ptr_t              head_r [NUM_LEVELS];
  ptr_t              tail_r [NUM_LEVELS];
  cnt_t              count_r [NUM_LEVELS];
  logic              out_valid_r;
  status_t           status_r;
  logic [LVL_W-1:0]  level_r;
  logic [DATA_W-1:0] rdata_r;
  logic [DATA_W-1:0] mem [NUM_LEVELS * QUEUE_DEPTH];

  logic              accept;
  logic [LIM_W-1:0]  limit;
  logic [1:0]        ins_q;
  logic [1:0]        rem_q;
  logic              any_full;
  logic              do_write;
  logic              do_read;
  ptr_t              ptr_sel;
  logic [1:0]        q_sel;
  logic [ADDR_W-1:0] addr;
  status_t           status_nxt;
  logic [LVL_W-1:0]  level_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // saturate capacity at the queue depth
  always_comb begin
    if (LIM_W'(cap_r) > DEPTH_LIM) begin
      limit = DEPTH_LIM;
    end else begin
      limit = LIM_W'(cap_r);
    end
  end

  assign ins_q = in_priority_level - 2'd1;

  always_comb begin
    if (count_r[0] != '0) begin
      rem_q = 2'd0;
    end else if (count_r[1] != '0) begin
      rem_q = 2'd1;
    end else begin
      rem_q = 2'd2;
    end
  end

  always_comb begin
    do_write   = 1'b0;
    do_read    = 1'b0;
    status_nxt = ST_EMPTY;
    level_nxt  = LEVEL_NONE;
    q_sel      = ins_q;
    any_full   = 1'b0;
    if (req_t'(in_req_type) == REQ_INSERT) begin
      q_sel = ins_q;
      if (in_priority_level == LEVEL_NONE) begin
        status_nxt = ST_INVALID;
      end else begin
        any_full = LIM_W'(count_r[ins_q]) >= limit;
        if (any_full) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          status_nxt = ST_INSERTED;
          do_write   = accept;
        end
      end
    end else begin
      q_sel = rem_q;
      if (count_r[rem_q] != '0) begin
        status_nxt = ST_REMOVED;
        level_nxt  = rem_q + 2'd1;
        do_read    = accept;
      end
    end
  end

  assign ptr_sel = (req_t'(in_req_type) == REQ_INSERT) ? tail_r[q_sel] : head_r[q_sel];

  always_comb begin
    case (q_sel)
      2'd0:    addr = ADDR_W'(ptr_sel);
      2'd1:    addr = ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr_sel);
      default: addr = ADDR_W'(2 * QUEUE_DEPTH) + ADDR_W'(ptr_sel);
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[addr] <= in_element_value;
    end
    if (do_read) begin
      rdata_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
      status_r    <= ST_EMPTY;
      level_r     <= LEVEL_NONE;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_r[i]  <= '0;
        tail_r[i]  <= '0;
        count_r[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_queue_capacity;
      end
      out_valid_r <= accept;
      if (accept) begin
        status_r <= status_nxt;
        level_r  <= level_nxt;
      end
      if (do_write) begin
        tail_r[q_sel]  <= (tail_r[q_sel] == PTR_LAST) ? '0 : tail_r[q_sel] + 1'b1;
        count_r[q_sel] <= count_r[q_sel] + 1'b1;
      end
      if (do_read) begin
        head_r[q_sel]  <= (head_r[q_sel] == PTR_LAST) ? '0 : head_r[q_sel] + 1'b1;
        count_r[q_sel] <= count_r[q_sel] - 1'b1;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_source_level  = level_r;
  assign out_removed_value = (status_r == ST_REMOVED) ? rdata_r : '0;

  // no level ever holds more than the queue depth
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r[0] <= DEPTH_CNT && count_r[1] <= DEPTH_CNT && count_r[2] <= DEPTH_CNT)
    else $error("queue fill above depth");

  // a successful remove always names the level served, others name none
  a_removed_level : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status_r == ST_REMOVED) |-> level_r != LEVEL_NONE)
    else $error("remove without source level");

  a_other_level : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status_r != ST_REMOVED) |-> level_r == LEVEL_NONE && out_removed_value == '0)
    else $error("non-remove result carries data");

  // memory is never written and read by the same request
  a_one_access : assert property (@(posedge clk) disable iff (!rst_n)
    !(do_write && do_read))
    else $error("write and read in one cycle");

  // a remove only fires when some level holds data
  a_remove_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    do_read |-> (count_r[0] != '0 || count_r[1] != '0 || count_r[2] != '0))
    else $error("remove from empty queues");

endmodule
